FILE: hdl/prim_mst_pkg.sv
// Shared constants, codes and types for the minimum spanning tree block.
package prim_mst_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int VERTEX_W      = 6;
    localparam int WEIGHT_PORT_W = 16;
    localparam int COUNT_W       = 7;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_EDGE  = 2'd1;
    localparam logic [1:0] FUNC_RUN   = 2'd2;

    typedef enum logic [1:0] {
        MX_CLEAR,
        MX_IDLE,
        MX_MIRROR
    } mx_state_t;

    typedef enum logic [2:0] {
        EN_IDLE,
        EN_RELAX,
        EN_DRAIN,
        EN_ROUND,
        EN_EMIT_RD,
        EN_EMIT_LOAD
    } en_state_t;

    typedef struct packed {
        logic                     clear_req;
        logic                     edge_req;
        logic [VERTEX_W-1:0]      vtx_a;
        logic [VERTEX_W-1:0]      vtx_b;
        logic [WEIGHT_PORT_W-1:0] weight;
    } mx_cmd_t;

endpackage

FILE: hdl/prim_mst_matrix.sv
// Adjacency matrix memory with clearing sweep and symmetric edge writes.
module prim_mst_matrix #(
    parameter int MAX_VERTICES = prim_mst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = prim_mst_pkg::WEIGHT_BITS_DEF,
    localparam int VB = $clog2(MAX_VERTICES),
    localparam int AW = 2 * VB
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  prim_mst_pkg::mx_cmd_t  cmd,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic [WEIGHT_BITS-1:0] rd_data,
    output logic                   busy
);
    import prim_mst_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_C = COUNT_W'(MAX_VERTICES);

    logic [WEIGHT_BITS-1:0] mem [2**AW];
    logic [WEIGHT_BITS-1:0] rd_data_reg;

    mx_state_t              state_reg, state_next;
    logic [AW-1:0]          sweep_reg, sweep_next;
    logic [AW-1:0]          mirror_addr_reg, mirror_addr_next;
    logic [WEIGHT_BITS-1:0] mirror_data_reg, mirror_data_next;
    logic                   mirror_ok_reg, mirror_ok_next;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic [31:0]            weight_ext;
    logic [WEIGHT_BITS-1:0] weight_masked;
    logic                   edge_ok;

    assign weight_ext    = 32'(cmd.weight);
    assign weight_masked = weight_ext[WEIGHT_BITS-1:0];
    assign edge_ok       = (COUNT_W'(cmd.vtx_a) < MAX_C) && (COUNT_W'(cmd.vtx_b) < MAX_C);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MX_CLEAR:
            begin
                if (sweep_reg == '1)
                begin
                    state_next = MX_IDLE;
                end
            end
            MX_IDLE:
            begin
                if (cmd.clear_req)
                begin
                    state_next = MX_CLEAR;
                end
                else if (cmd.edge_req)
                begin
                    state_next = MX_MIRROR;
                end
            end
            MX_MIRROR:
            begin
                state_next = MX_IDLE;
            end
            default:
            begin
                state_next = MX_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_en            = 1'b0;
        wr_addr          = sweep_reg;
        wr_data          = '0;
        sweep_next       = sweep_reg;
        mirror_addr_next = mirror_addr_reg;
        mirror_data_next = mirror_data_reg;
        mirror_ok_next   = mirror_ok_reg;
        busy             = 1'b1;
        unique case (state_reg)
            MX_CLEAR:
            begin
                wr_en      = 1'b1;
                sweep_next = sweep_reg + AW'(1);
            end
            MX_IDLE:
            begin
                busy = 1'b0;
                if (cmd.clear_req)
                begin
                    sweep_next = '0;
                end
                else if (cmd.edge_req)
                begin
                    // write (a, b) now, hold (b, a) for the next cycle
                    wr_en            = edge_ok;
                    wr_addr          = {cmd.vtx_a[VB-1:0], cmd.vtx_b[VB-1:0]};
                    wr_data          = weight_masked;
                    mirror_addr_next = {cmd.vtx_b[VB-1:0], cmd.vtx_a[VB-1:0]};
                    mirror_data_next = weight_masked;
                    mirror_ok_next   = edge_ok;
                end
            end
            MX_MIRROR:
            begin
                wr_en   = mirror_ok_reg;
                wr_addr = mirror_addr_reg;
                wr_data = mirror_data_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= MX_CLEAR;
            sweep_reg     <= '0;
            mirror_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            mirror_ok_reg <= mirror_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mirror_addr_reg <= mirror_addr_next;
        mirror_data_reg <= mirror_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/prim_mst_engine.sv
// Prim sequencer: vertex table memory, relax-and-select passes, tree word output.
module prim_mst_engine #(
    parameter int MAX_VERTICES = prim_mst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = prim_mst_pkg::WEIGHT_BITS_DEF,
    localparam int VB = $clog2(MAX_VERTICES),
    localparam int AW = 2 * VB,
    localparam int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    run_start,
    input  logic [CW-1:0]                           run_count,
    output logic                                    adj_rd_en,
    output logic [AW-1:0]                           adj_rd_addr,
    input  logic [WEIGHT_BITS-1:0]                  adj_rd_data,
    output logic                                    busy,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [prim_mst_pkg::VERTEX_W-1:0]       end_low,
    output logic [prim_mst_pkg::VERTEX_W-1:0]       end_high,
    output logic [prim_mst_pkg::WEIGHT_PORT_W-1:0]  tree_weight,
    output logic                                    connected,
    output logic                                    last
);
    import prim_mst_pkg::*;

    localparam int KW    = WEIGHT_BITS + 1;
    localparam int ENT_W = 1 + KW + VB;
    localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    // vertex table entry: {visited, key, parent}
    logic [ENT_W-1:0] vt_mem [2**VB];
    logic [ENT_W-1:0] vt_rd_data_reg;
    logic             vt_rd_en;
    logic [VB-1:0]    vt_rd_addr;
    logic             vt_wr_en;
    logic [VB-1:0]    vt_wr_addr;
    logic [ENT_W-1:0] vt_wr_data;

    en_state_t        state_reg, state_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [VB-1:0]    sel_reg, sel_next;
    logic             first_reg, first_next;
    logic [CW-1:0]    j_reg, j_next;
    logic             p_valid_reg, p_valid_next;
    logic [VB-1:0]    p_idx_reg, p_idx_next;
    logic [KW-1:0]    best_key_reg, best_key_next;
    logic [VB-1:0]    best_idx_reg, best_idx_next;

    logic                     out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0]      end_low_reg, end_low_next;
    logic [VERTEX_W-1:0]      end_high_reg, end_high_next;
    logic [WEIGHT_PORT_W-1:0] weight_reg, weight_next;
    logic                     connected_reg, connected_next;
    logic                     last_reg, last_next;

    logic             rd_vis;
    logic [KW-1:0]    rd_key;
    logic [VB-1:0]    rd_par;
    logic             cur_vis, new_vis;
    logic [KW-1:0]    cur_key, new_key, w_key;
    logic [VB-1:0]    cur_par, new_par;
    logic             cand;

    logic [VB-1:0]    i_idx;
    logic [CW-1:0]    j_plus;
    logic             is_last;
    logic             found;
    logic             slot_free;
    logic             load;
    logic [31:0]      key_ext;

    assign rd_vis  = vt_rd_data_reg[ENT_W-1];
    assign rd_key  = vt_rd_data_reg[VB +: KW];
    assign rd_par  = vt_rd_data_reg[VB-1:0];

    assign i_idx     = j_reg[VB-1:0];
    assign j_plus    = j_reg + CW'(1);
    assign is_last   = (j_reg == n_reg - CW'(1));
    assign found     = (best_key_reg < KEY_INF);
    assign slot_free = !out_valid_reg || out_ready;
    assign key_ext   = 32'(rd_key);

    // relax stage: one neighbor per cycle, running minimum for the next round
    always_comb
    begin
        if (first_reg)
        begin
            cur_vis = 1'b0;
            cur_key = (p_idx_reg == '0) ? '0 : KEY_INF;
            cur_par = '0;
        end
        else
        begin
            cur_vis = rd_vis;
            cur_key = rd_key;
            cur_par = rd_par;
        end
        w_key   = {1'b0, adj_rd_data};
        new_vis = cur_vis;
        new_key = cur_key;
        new_par = cur_par;
        if (p_idx_reg == sel_reg)
        begin
            new_vis = 1'b1;
        end
        else if (!cur_vis && (adj_rd_data != '0) && (w_key < cur_key))
        begin
            new_key = w_key;
            new_par = sel_reg;
        end
        cand       = p_valid_reg && !new_vis && (new_key < best_key_reg);
        vt_wr_en   = p_valid_reg;
        vt_wr_addr = p_idx_reg;
        vt_wr_data = {new_vis, new_key, new_par};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EN_IDLE:
            begin
                if (run_start)
                begin
                    state_next = EN_RELAX;
                end
            end
            EN_RELAX:
            begin
                if (is_last)
                begin
                    state_next = EN_DRAIN;
                end
            end
            EN_DRAIN:
            begin
                state_next = EN_ROUND;
            end
            EN_ROUND:
            begin
                state_next = found ? EN_RELAX : EN_EMIT_RD;
            end
            EN_EMIT_RD:
            begin
                state_next = EN_EMIT_LOAD;
            end
            EN_EMIT_LOAD:
            begin
                if (slot_free && is_last)
                begin
                    state_next = EN_IDLE;
                end
            end
            default:
            begin
                state_next = EN_IDLE;
            end
        endcase
    end

    always_comb
    begin
        n_next        = n_reg;
        sel_next      = sel_reg;
        first_next    = first_reg;
        j_next        = j_reg;
        p_valid_next  = 1'b0;
        p_idx_next    = j_reg[VB-1:0];
        best_key_next = best_key_reg;
        best_idx_next = best_idx_reg;
        adj_rd_en     = 1'b0;
        vt_rd_en      = 1'b0;
        vt_rd_addr    = j_reg[VB-1:0];
        load          = 1'b0;

        if (cand)
        begin
            best_key_next = new_key;
            best_idx_next = p_idx_reg;
        end

        unique case (state_reg)
            EN_IDLE:
            begin
                if (run_start)
                begin
                    n_next        = run_count;
                    sel_next      = '0;
                    first_next    = 1'b1;
                    j_next        = '0;
                    best_key_next = KEY_INF;
                end
            end
            EN_RELAX:
            begin
                adj_rd_en    = 1'b1;
                vt_rd_en     = 1'b1;
                p_valid_next = 1'b1;
                j_next       = j_plus;
            end
            EN_DRAIN:
            begin
                j_next = j_reg;
            end
            EN_ROUND:
            begin
                sel_next      = best_idx_reg;
                first_next    = 1'b0;
                best_key_next = KEY_INF;
                j_next        = found ? '0 : CW'(1);
            end
            EN_EMIT_RD:
            begin
                vt_rd_en = 1'b1;
            end
            EN_EMIT_LOAD:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    if (!is_last)
                    begin
                        j_next     = j_plus;
                        vt_rd_en   = 1'b1;
                        vt_rd_addr = j_plus[VB-1:0];
                    end
                end
            end
            default:
            begin
                j_next = j_reg;
            end
        endcase
    end

    // tree word from the vertex table entry of vertex j
    always_comb
    begin
        out_valid_next = out_valid_reg;
        end_low_next   = end_low_reg;
        end_high_next  = end_high_reg;
        weight_next    = weight_reg;
        connected_next = connected_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            connected_next = rd_vis;
            last_next      = is_last;
            if (rd_vis)
            begin
                end_low_next  = VERTEX_W'((rd_par < i_idx) ? rd_par : i_idx);
                end_high_next = VERTEX_W'((rd_par < i_idx) ? i_idx : rd_par);
                weight_next   = key_ext[WEIGHT_PORT_W-1:0];
            end
            else
            begin
                end_low_next  = '0;
                end_high_next = VERTEX_W'(i_idx);
                weight_next   = '0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EN_IDLE;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        sel_reg       <= sel_next;
        first_reg     <= first_next;
        j_reg         <= j_next;
        p_idx_reg     <= p_idx_next;
        best_key_reg  <= best_key_next;
        best_idx_reg  <= best_idx_next;
        end_low_reg   <= end_low_next;
        end_high_reg  <= end_high_next;
        weight_reg    <= weight_next;
        connected_reg <= connected_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (vt_wr_en)
        begin
            vt_mem[vt_wr_addr] <= vt_wr_data;
        end
        if (vt_rd_en)
        begin
            vt_rd_data_reg <= vt_mem[vt_rd_addr];
        end
    end

    assign adj_rd_addr = {sel_reg, j_reg[VB-1:0]};
    assign busy        = (state_reg != EN_IDLE);
    assign out_valid   = out_valid_reg;
    assign end_low     = end_low_reg;
    assign end_high    = end_high_reg;
    assign tree_weight = weight_reg;
    assign connected   = connected_reg;
    assign last        = last_reg;

endmodule

FILE: hdl/prim_minimum_spanning_tree.sv
// Top level of the minimum spanning tree block: input decode, vertex count register.
//
// Holds a symmetric weighted adjacency matrix (weight 0 = no edge) in one
// synchronous memory and runs Prim's algorithm from vertex 0 over the
// first vertex_count vertices (clamped to 2 .. MAX_VERTICES). After reset,
// and after every clear word, a clearing pass writes zero to the matrix one
// entry per cycle, during which in_ready stays low (vertex_count writes are
// taken at any time). An edge word makes one matrix write per direction.
// A run word walks the matrix row of the selected vertex one column per
// cycle through the single read port, relaxing keys in a vertex table
// memory and tracking the next minimum on the fly, with at most n rounds
// for n vertices, fewer when vertices are unreachable. Then one tree word
// per vertex 1 .. n-1 leaves at up to one per cycle while out_ready is
// high, with last set on the final one; an unreachable vertex comes out
// with connected low, end_low 0, end_high the vertex and tree_weight 0.
// The output register holds the final word while a new input word is
// taken.
module prim_minimum_spanning_tree #(
    parameter int MAX_VERTICES = prim_mst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = prim_mst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [prim_mst_pkg::COUNT_W-1:0]        cfg_wr_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              func,
    input  logic [prim_mst_pkg::VERTEX_W-1:0]       vertex_a,
    input  logic [prim_mst_pkg::VERTEX_W-1:0]       vertex_b,
    input  logic [prim_mst_pkg::WEIGHT_PORT_W-1:0]  edge_weight,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [prim_mst_pkg::VERTEX_W-1:0]       end_low,
    output logic [prim_mst_pkg::VERTEX_W-1:0]       end_high,
    output logic [prim_mst_pkg::WEIGHT_PORT_W-1:0]  tree_weight,
    output logic                                    connected,
    output logic                                    last
);
    import prim_mst_pkg::*;

    localparam int VB = $clog2(MAX_VERTICES);
    localparam int AW = 2 * VB;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [COUNT_W-1:0] MAX_C = COUNT_W'(MAX_VERTICES);
    localparam logic [COUNT_W-1:0] MIN_C = COUNT_W'(2);

    logic [COUNT_W-1:0] vertex_count_reg, vertex_count_next;
    logic [COUNT_W-1:0] count_clamped;
    logic               accept;
    logic               run_start;
    mx_cmd_t            mx_cmd;

    logic                   mx_busy;
    logic                   en_busy;
    logic                   adj_rd_en;
    logic [AW-1:0]          adj_rd_addr;
    logic [WEIGHT_BITS-1:0] adj_rd_data;

    // take a word only when both the matrix and the sequencer are idle
    assign in_ready = !mx_busy && !en_busy;
    assign accept   = in_valid && in_ready;

    assign mx_cmd.clear_req = accept && (func == FUNC_CLEAR);
    assign mx_cmd.edge_req  = accept && (func == FUNC_EDGE);
    assign mx_cmd.vtx_a     = vertex_a;
    assign mx_cmd.vtx_b     = vertex_b;
    assign mx_cmd.weight    = edge_weight;
    assign run_start        = accept && (func == FUNC_RUN);

    // clamp the vertex count into the supported range at run start
    always_comb
    begin
        if (vertex_count_reg < MIN_C)
        begin
            count_clamped = MIN_C;
        end
        else if (vertex_count_reg > MAX_C)
        begin
            count_clamped = MAX_C;
        end
        else
        begin
            count_clamped = vertex_count_reg;
        end
    end

    assign vertex_count_next = cfg_wr_en ? cfg_wr_data : vertex_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    prim_mst_matrix #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mx_cmd),
        .rd_en   (adj_rd_en),
        .rd_addr (adj_rd_addr),
        .rd_data (adj_rd_data),
        .busy    (mx_busy)
    );

    prim_mst_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .run_start   (run_start),
        .run_count   (CW'(count_clamped)),
        .adj_rd_en   (adj_rd_en),
        .adj_rd_addr (adj_rd_addr),
        .adj_rd_data (adj_rd_data),
        .busy        (en_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .end_low     (end_low),
        .end_high    (end_high),
        .tree_weight (tree_weight),
        .connected   (connected),
        .last        (last)
    );

endmodule

FILE: hdl/prim_mst_checker.sv
// Port-level checks for the minimum spanning tree block, bound to the top level.
module prim_mst_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic [1:0]                              func,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic [prim_mst_pkg::VERTEX_W-1:0]       end_low,
    input logic [prim_mst_pkg::VERTEX_W-1:0]       end_high,
    input logic [prim_mst_pkg::WEIGHT_PORT_W-1:0]  tree_weight,
    input logic                                    connected,
    input logic                                    last
);
    import prim_mst_pkg::*;

    // a stalled tree word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(end_low) && $stable(end_high)
            && $stable(tree_weight) && $stable(connected) && $stable(last))
        else $error("tree word changed while stalled");

    // every clear, edge or run word leaves the block busy, with in_ready low, once it is taken
    a_busy_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == FUNC_CLEAR || func == FUNC_EDGE || func == FUNC_RUN)
            |=> !in_ready)
        else $error("input taken right after a working word");

    // hold off input while a word before the final one of a run sits in the output register
    a_run_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken in the middle of a run");

    // a reached vertex is never its own parent
    a_tree_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && connected |-> end_low < end_high)
        else $error("tree edge endpoints out of order");

    // an unreached vertex reports no edge
    a_unreached_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !connected |-> end_low == '0 && tree_weight == '0)
        else $error("unreached vertex reported with an edge");

endmodule

bind prim_minimum_spanning_tree prim_mst_checker u_checker (.*);

FILE: tb/sv/prim_minimum_spanning_tree_tb.sv
// Self-checking testbench for the Prim minimum spanning tree block.
module prim_minimum_spanning_tree_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prim_mst_pkg::*;

    localparam int MAX_V = MAX_VERTICES_DEF;
    localparam int KEY_W = WEIGHT_BITS_DEF + 1;
    localparam logic [KEY_W-1:0] KEY_INF = {1'b1, {WEIGHT_BITS_DEF{1'b0}}};
    // func code 3 is reserved: the block drops the word.
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // Worst clearing pass (4096 entries) plus an edge write, with margin.
    localparam int SETTLE_CYCLES = 4200;
    // Margin for the longest run at 64 vertices.
    localparam int DRAIN_CYCLES  = 4500;
    localparam int RANDOM_WORDS  = 450;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef struct packed {
        logic [VERTEX_W-1:0]      lo;
        logic [VERTEX_W-1:0]      hi;
        logic [WEIGHT_PORT_W-1:0] weight;
        logic                     conn;
        logic                     fin;
    } tree_edge_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [COUNT_W-1:0]       cfg_wr_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               func;
    logic [VERTEX_W-1:0]      vertex_a;
    logic [VERTEX_W-1:0]      vertex_b;
    logic [WEIGHT_PORT_W-1:0] edge_weight;
    logic                     out_valid;
    logic                     out_ready;
    logic [VERTEX_W-1:0]      end_low;
    logic [VERTEX_W-1:0]      end_high;
    logic [WEIGHT_PORT_W-1:0] tree_weight;
    logic                     connected;
    logic                     last;

    prim_minimum_spanning_tree u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .vertex_a    (vertex_a),
        .vertex_b    (vertex_b),
        .edge_weight (edge_weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .end_low     (end_low),
        .end_high    (end_high),
        .tree_weight (tree_weight),
        .connected   (connected),
        .last        (last)
    );

    // Shadow copy of the block: matrix, run tables and the count register.
    logic [WEIGHT_PORT_W-1:0] adj_model [MAX_V][MAX_V];
    logic                     visited_model [MAX_V];
    logic [KEY_W-1:0]         key_model [MAX_V];
    logic [VERTEX_W-1:0]      parent_model [MAX_V];
    logic [COUNT_W-1:0]       vertex_count_model;

    // Tree words predicted but not yet seen on the output, oldest first.
    tree_edge_t pending_tree_edges [$];

    int  error_count = 0;
    int  words_sent  = 0;
    int  runs_sent   = 0;
    int  clears_sent = 0;
    int  words_seen  = 0;
    bit  steady_flow = 1'b1;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("prim_minimum_spanning_tree_tb failed");
        $finish;
    end

    // Mostly short idle gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A run clamps the register to 2 .. MAX_V.
    function automatic int effective_count(logic [COUNT_W-1:0] raw);
        int n;
        n = int'(raw);
        if (n < 2)
            n = 2;
        if (n > MAX_V)
            n = MAX_V;
        return n;
    endfunction

    // Prim from vertex 0, then queue one tree word per vertex 1 .. n-1.
    function automatic void compute_tree_edges();
        int         n;
        int         sel;
        int         p;
        bit         found;
        bit         stop;
        tree_edge_t t;
        n = effective_count(vertex_count_model);
        for (int i = 0; i < n; i++) begin
            visited_model[i] = 1'b0;
            key_model[i]     = KEY_INF;
            parent_model[i]  = '0;
        end
        key_model[0] = '0;
        stop = 1'b0;
        for (int r = 0; r < n && !stop; r++) begin
            sel   = 0;
            found = 1'b0;
            // Strict less-than keeps ties on the lowest index.
            for (int i = 0; i < n; i++) begin
                if (!visited_model[i] && (!found || key_model[i] < key_model[sel])) begin
                    sel   = i;
                    found = 1'b1;
                end
            end
            // Remaining vertices all at infinity: nothing more is reachable.
            if (!found || key_model[sel] >= KEY_INF) begin
                stop = 1'b1;
            end else begin
                visited_model[sel] = 1'b1;
                for (int j = 0; j < n; j++) begin
                    if (adj_model[sel][j] != '0 && !visited_model[j]
                        && {1'b0, adj_model[sel][j]} < key_model[j]) begin
                        key_model[j]    = {1'b0, adj_model[sel][j]};
                        parent_model[j] = VERTEX_W'(sel);
                    end
                end
            end
        end
        for (int i = 1; i < n; i++) begin
            if (visited_model[i]) begin
                p        = int'(parent_model[i]);
                t.lo     = VERTEX_W'((p < i) ? p : i);
                t.hi     = VERTEX_W'((p < i) ? i : p);
                t.weight = key_model[i][WEIGHT_PORT_W-1:0];
                t.conn   = 1'b1;
            end else begin
                // Unreached vertex: reported as a lone end point.
                t.lo     = '0;
                t.hi     = VERTEX_W'(i);
                t.weight = '0;
                t.conn   = 1'b0;
            end
            t.fin = (i == n - 1);
            pending_tree_edges.push_back(t);
        end
    endfunction

    // Present one word, hold it until taken, then update the shadow state.
    task automatic send_word(input logic [1:0] f, input logic [VERTEX_W-1:0] a,
                             input logic [VERTEX_W-1:0] b,
                             input logic [WEIGHT_PORT_W-1:0] w);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        func        <= f;
        vertex_a    <= a;
        vertex_b    <= b;
        edge_weight <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Accepted at this edge.
        case (f)
            FUNC_CLEAR: begin
                foreach (adj_model[i, j])
                    adj_model[i][j] = '0;
                clears_sent++;
            end
            FUNC_EDGE: begin
                adj_model[a][b] = w;
                adj_model[b][a] = w;
            end
            FUNC_RUN: begin
                compute_tree_edges();
                runs_sent++;
            end
            default: ;
        endcase
        if (f != FUNC_NONE)
            words_sent++;
    endtask

    // Drop valid and hold off until every predicted tree word has come out.
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_tree_edges.size() != 0)
            @(negedge clk);
    endtask

    // Write the count register once the block is idle.
    task automatic program_vertex_count(input logic [COUNT_W-1:0] value);
        wait_results_drained();
        // A clear or edge word may still be busy with no result to show it.
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        vertex_count_model = value;
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: tree word %0d %s mismatch: expected %0d, actual %0d",
                     $time, words_seen, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Output checker: every accepted tree word against the oldest prediction.
    always @(posedge clk) begin
        tree_edge_t exp_word;
        if (rst_n && out_valid && out_ready) begin
            if (pending_tree_edges.size() == 0) begin
                $display("%0t ns: unexpected tree word: expected none, actual %0d-%0d w %0d c %0b l %0b",
                         $time, end_low, end_high, tree_weight, connected, last);
                error_count++;
            end else begin
                exp_word = pending_tree_edges.pop_front();
                check_field("end_low", exp_word.lo, end_low);
                check_field("end_high", exp_word.hi, end_high);
                check_field("tree_weight", exp_word.weight, tree_weight);
                check_field("connected", exp_word.conn, connected);
                check_field("last", exp_word.fin, last);
            end
            words_seen++;
        end
    end

    // Output back-pressure: random stalls unless the flow is held steady.
    initial begin
        int stall;
        out_ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
                if (!steady_flow)
                    stall = pick_gap();
            end
        end
    end

    // Empty matrix at the reset count of 64: every vertex comes out unreached.
    task automatic test_empty_matrix_after_reset();
        steady_flow = 1'b1;
        send_word(FUNC_RUN, '0, '0, '0);
        wait_results_drained();
    endtask

    // Hand-built graph on 7 vertices covering the corner cases.
    task automatic test_directed_graph();
        steady_flow = 1'b0;
        program_vertex_count(7'd7);
        send_word(FUNC_EDGE, 6'd0, 6'd1, 16'hFFFF);
        send_word(FUNC_EDGE, 6'd1, 6'd0, 16'd40);   // overwrite from the other side
        send_word(FUNC_EDGE, 6'd0, 6'd2, 16'd1);
        send_word(FUNC_EDGE, 6'd2, 6'd1, 16'd2);    // parent of 1 is the larger vertex 2
        send_word(FUNC_EDGE, 6'd2, 6'd3, 16'd9);
        send_word(FUNC_EDGE, 6'd2, 6'd4, 16'd9);    // equal keys on 3 and 4
        send_word(FUNC_EDGE, 6'd1, 6'd3, 16'd9);    // equal weight must not relax
        send_word(FUNC_EDGE, 6'd3, 6'd3, 16'd1);    // self loop
        send_word(FUNC_EDGE, 6'd4, 6'd5, 16'hFFFF);
        send_word(FUNC_EDGE, 6'd5, 6'd6, 16'd7);
        send_word(FUNC_EDGE, 6'd6, 6'd5, 16'd0);    // remove again: 6 unreached
        send_word(FUNC_EDGE, 6'd6, 6'd63, 16'd2);   // neighbor outside the run
        send_word(FUNC_NONE, 6'd63, 6'd63, 16'hFFFF);
        send_word(FUNC_RUN, 6'd63, 6'd0, 16'hAAAA);
        // Back-to-back run on the same matrix.
        send_word(FUNC_RUN, '0, '0, '0);
    endtask

    // Clear, then the register below and above its legal range.
    task automatic test_clear_and_clamp();
        send_word(FUNC_CLEAR, 6'd63, 6'd63, 16'hFFFF);
        send_word(FUNC_RUN, '0, '0, '0);
        program_vertex_count(7'd0);
        send_word(FUNC_EDGE, 6'd0, 6'd1, 16'd1);
        send_word(FUNC_RUN, '0, '0, '0);
        program_vertex_count(7'd127);
        send_word(FUNC_EDGE, 6'd62, 6'd63, 16'hFFFF);
        send_word(FUNC_EDGE, 6'd0, 6'd63, 16'd1);
        send_word(FUNC_RUN, '0, '0, '0);
        program_vertex_count(7'd1);
        send_word(FUNC_RUN, '0, '0, '0);
    endtask

    // Random phases: set a count, build a random graph, run one or more times.
    task automatic test_random_graphs();
        int                       target;
        int                       roll;
        int                       span;
        int                       rounds;
        int                       edges;
        logic [COUNT_W-1:0]       cnt;
        logic [VERTEX_W-1:0]      a;
        logic [VERTEX_W-1:0]      b;
        logic [WEIGHT_PORT_W-1:0] w;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                cnt = COUNT_W'($urandom_range(2, 10));
            else if (roll < 72)
                cnt = COUNT_W'($urandom_range(11, 24));
            else if (roll < 80)
                cnt = COUNT_W'($urandom_range(25, 63));
            else if (roll < 87)
                cnt = 7'd64;
            else if (roll < 94)
                cnt = COUNT_W'($urandom_range(65, 127));
            else
                cnt = COUNT_W'($urandom_range(0, 1));
            program_vertex_count(cnt);
            span = effective_count(cnt);
            steady_flow = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                send_word(FUNC_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom),
                          WEIGHT_PORT_W'($urandom));
            rounds = (span > 24) ? 1 : $urandom_range(1, 3);
            repeat (rounds) begin
                edges = (span > 24) ? $urandom_range(span / 2, 2 * span)
                                    : $urandom_range(0, 2 * span);
                repeat (edges) begin
                    // Occasional reserved code mixed in.
                    if ($urandom_range(0, 15) == 0)
                        send_word(FUNC_NONE, VERTEX_W'($urandom), VERTEX_W'($urandom),
                                  WEIGHT_PORT_W'($urandom));
                    if ($urandom_range(0, 9) == 0) begin
                        a = VERTEX_W'($urandom_range(0, MAX_V - 1));
                        b = VERTEX_W'($urandom_range(0, MAX_V - 1));
                    end else begin
                        a = VERTEX_W'($urandom_range(0, span - 1));
                        b = VERTEX_W'($urandom_range(0, span - 1));
                    end
                    if ($urandom_range(0, 19) == 0)
                        b = a;
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: w = WEIGHT_PORT_W'($urandom_range(1, 4));
                        4:          w = '0;
                        5:          w = '1;
                        6:          w = WEIGHT_PORT_W'($urandom_range(1, 255));
                        default:    w = WEIGHT_PORT_W'($urandom);
                    endcase
                    send_word(FUNC_EDGE, a, b, w);
                end
                // Now and then hold the sender until the block has emptied.
                if ($urandom_range(0, 7) == 0)
                    wait_results_drained();
                send_word(FUNC_RUN, VERTEX_W'($urandom), VERTEX_W'($urandom),
                          WEIGHT_PORT_W'($urandom));
            end
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        func        = FUNC_CLEAR;
        vertex_a    = '0;
        vertex_b    = '0;
        edge_weight = '0;
        foreach (adj_model[i, j])
            adj_model[i][j] = '0;
        for (int i = 0; i < MAX_V; i++) begin
            visited_model[i] = 1'b0;
            key_model[i]     = KEY_INF;
            parent_model[i]  = '0;
        end
        vertex_count_model = VERTEX_COUNT_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_matrix_after_reset();
        test_directed_graph();
        test_clear_and_clamp();
        test_random_graphs();

        // Let any stray word show up before the verdict.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d input words (%0d runs, %0d clears), vertex counts 0..127",
                 words_sent, runs_sent, clears_sent);
        $display("Checked %0d tree words against the shadow model, %0d mismatches",
                 words_seen, error_count);
        if (error_count == 0)
            $display("prim_minimum_spanning_tree_tb passed");
        else
            $display("prim_minimum_spanning_tree_tb failed");
        $finish;
    end

endmodule
